[rtl/ffea_pkg.sv]
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared constants, status codes and types of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

    localparam int GRANULE_BYTES = 8;
    localparam int MAX_EXTENTS   = 16;
    localparam int HEAP_BASE     = 0;
    localparam int HEAP_LIMIT    = 65536;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int END_W  = 18;
    localparam int CFG_W  = 17;
    localparam int IDX_W  = $clog2(MAX_EXTENTS);
    localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
    localparam int GRN_W  = $clog2(GRANULE_BYTES);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
    } t_ext;

    localparam int EXT_W = $bits(t_ext);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_ext             wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } t_res;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } t_req;

endpackage

[rtl/ffea_ram.sv]
// ----------------------------------------------------------------------------
// ffea_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffea_ctrl.sv]
// ----------------------------------------------------------------------------
// ffea_ctrl
// Request sequencer: scans the extent table, then edits it in place.
// ----------------------------------------------------------------------------
module ffea_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_init,
    input  logic [ffea_pkg::LEN_W-1:0] i_heap,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  ffea_pkg::t_req             i_req,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output ffea_pkg::t_res             o_res,
    output ffea_pkg::t_ram_req         o_ram,
    input  ffea_pkg::t_ext             i_rdata,
    output logic                       o_idle
);
    import ffea_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_DN_RD = 4'd5;
    localparam logic [3:0] S_DN_WR = 4'd6;
    localparam logic [3:0] S_UP_RD = 4'd7;
    localparam logic [3:0] S_UP_WR = 4'd8;
    localparam logic [3:0] S_INS   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_mode,  n_mode;
    logic [LEN_W-1:0]  r_sz,    n_sz;
    logic [ADDR_W-1:0] r_addr,  n_addr;
    logic [END_W-1:0]  r_end,   n_end;
    logic [CNT_W-1:0]  r_idx,   n_idx;
    logic [CNT_W-1:0]  r_pos,   n_pos;
    logic [CNT_W-1:0]  r_k,     n_k;
    logic              r_pv,    n_pv;
    logic              r_nv,    n_nv;
    t_ext              r_prev,  n_prev;
    t_ext              r_next,  n_next;
    t_res              r_res,   n_res;

    logic [LEN_W-1:0]  rnd_sz;
    logic [END_W-1:0]  req_end;
    logic [END_W-1:0]  heap_end;
    logic [END_W-1:0]  d_end;
    logic [END_W-1:0]  prev_end;
    logic [LEN_W-1:0]  d_rem;
    logic              last;
    logic              mprev;
    logic              mnext;
    logic [CNT_W-1:0]  pos_m1;

    always_comb begin
        // round up to the granule, zero becomes one granule
        rnd_sz = LEN_W'((({1'b0, i_req.size} + LEN_W'(GRANULE_BYTES - 1)) >> GRN_W) << GRN_W);
        if (rnd_sz == '0) begin
            rnd_sz = LEN_W'(GRANULE_BYTES);
        end
        req_end  = END_W'(i_req.addr) + END_W'(rnd_sz);
        heap_end = END_W'(i_heap) + END_W'(HEAP_BASE);
        d_end    = END_W'(i_rdata.start) + END_W'(i_rdata.len);
        prev_end = END_W'(r_prev.start) + END_W'(r_prev.len);
        d_rem    = i_rdata.len - r_sz;
        last     = (CNT_W'(r_idx + 1'b1) == r_count);
        mprev    = r_pv && (prev_end == END_W'(r_addr));
        mnext    = r_nv && (END_W'(r_next.start) == r_end);
        pos_m1   = CNT_W'(r_pos - 1'b1);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_mode  = r_mode;
        n_sz    = r_sz;
        n_addr  = r_addr;
        n_end   = r_end;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_k     = r_k;
        n_pv    = r_pv;
        n_nv    = r_nv;
        n_prev  = r_prev;
        n_next  = r_next;
        n_res   = r_res;
        o_ram       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_INIT: begin
                o_ram.we          = 1'b1;
                o_ram.waddr       = '0;
                o_ram.wdata.start = ADDR_W'(HEAP_BASE);
                o_ram.wdata.len   = i_heap;
                n_count = (i_heap != '0) ? CNT_W'(1) : '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = !i_init;
                if (i_init) begin
                    n_state = S_INIT;
                end else if (i_req_valid) begin
                    n_mode = i_req.mode;
                    n_sz   = rnd_sz;
                    n_addr = i_req.addr;
                    n_end  = req_end;
                    n_idx  = '0;
                    n_pos  = '0;
                    n_pv   = 1'b0;
                    n_nv   = 1'b0;
                    n_res  = '{status: ST_OK, addr: '0};
                    if (i_req.mode != MODE_ALLOC && req_end > heap_end) begin
                        n_res.status = ST_BAD_FREE;
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        if (i_req.mode == MODE_ALLOC) begin
                            n_res.status = ST_NO_FIT;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_INS;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_ram.raddr = r_idx[IDX_W-1:0];
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_mode == MODE_ALLOC) begin
                    if (i_rdata.len >= r_sz) begin
                        if (i_rdata.len == r_sz) begin
                            n_res.addr = i_rdata.start;
                            n_k = r_idx;
                            if (!last) begin
                                n_state = S_DN_RD;
                            end else begin
                                n_count = CNT_W'(r_count - 1'b1);
                                n_state = S_DONE;
                            end
                        end else begin
                            // carve from the end of the extent
                            o_ram.we          = 1'b1;
                            o_ram.waddr       = r_idx[IDX_W-1:0];
                            o_ram.wdata.start = i_rdata.start;
                            o_ram.wdata.len   = d_rem;
                            n_res.addr = ADDR_W'(i_rdata.start + d_rem[ADDR_W-1:0]);
                            n_state = S_DONE;
                        end
                    end else if (last) begin
                        n_res.status = ST_NO_FIT;
                        n_state = S_DONE;
                    end else begin
                        n_idx = CNT_W'(r_idx + 1'b1);
                        n_state = S_RD;
                    end
                end else begin
                    if (END_W'(r_addr) < d_end && END_W'(i_rdata.start) < r_end) begin
                        n_res.status = ST_BAD_FREE;
                        n_state = S_DONE;
                    end else begin
                        if (i_rdata.start < r_addr) begin
                            n_pv   = 1'b1;
                            n_prev = i_rdata;
                            n_pos  = CNT_W'(r_idx + 1'b1);
                        end else if (!r_nv) begin
                            n_nv   = 1'b1;
                            n_next = i_rdata;
                        end
                        if (last) begin
                            n_state = S_DEC;
                        end else begin
                            n_idx = CNT_W'(r_idx + 1'b1);
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_DEC: begin
                if (mprev && mnext) begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = pos_m1[IDX_W-1:0];
                    o_ram.wdata.start = r_prev.start;
                    o_ram.wdata.len   = LEN_W'(r_prev.len + r_sz + r_next.len);
                    n_k = r_pos;
                    if (CNT_W'(r_pos + 1'b1) < r_count) begin
                        n_state = S_DN_RD;
                    end else begin
                        n_count = CNT_W'(r_count - 1'b1);
                        n_state = S_DONE;
                    end
                end else if (mprev) begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = pos_m1[IDX_W-1:0];
                    o_ram.wdata.start = r_prev.start;
                    o_ram.wdata.len   = LEN_W'(r_prev.len + r_sz);
                    n_state = S_DONE;
                end else if (mnext) begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = r_pos[IDX_W-1:0];
                    o_ram.wdata.start = r_addr;
                    o_ram.wdata.len   = LEN_W'(r_next.len + r_sz);
                    n_state = S_DONE;
                end else if (r_count == CNT_MAX) begin
                    n_res.status = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_k = r_count;
                    n_state = (r_count > r_pos) ? S_UP_RD : S_INS;
                end
            end
            S_DN_RD: begin
                o_ram.raddr = IDX_W'(r_k + 1'b1);
                n_state = S_DN_WR;
            end
            S_DN_WR: begin
                // close the gap: entry k takes entry k+1
                o_ram.we    = 1'b1;
                o_ram.waddr = r_k[IDX_W-1:0];
                o_ram.wdata = i_rdata;
                n_k = CNT_W'(r_k + 1'b1);
                if (CNT_W'(r_k + 2'd2) < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = S_DONE;
                end
            end
            S_UP_RD: begin
                o_ram.raddr = IDX_W'(r_k - 1'b1);
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                // open a slot: entry k takes entry k-1
                o_ram.we    = 1'b1;
                o_ram.waddr = r_k[IDX_W-1:0];
                o_ram.wdata = i_rdata;
                n_k = CNT_W'(r_k - 1'b1);
                n_state = (CNT_W'(r_k - 1'b1) > r_pos) ? S_UP_RD : S_INS;
            end
            S_INS: begin
                o_ram.we          = 1'b1;
                o_ram.waddr       = r_pos[IDX_W-1:0];
                o_ram.wdata.start = r_addr;
                o_ram.wdata.len   = r_sz;
                n_count = CNT_W'(r_count + 1'b1);
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_res  = r_res;
    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_mode <= n_mode;
        r_sz   <= n_sz;
        r_addr <= n_addr;
        r_end  <= n_end;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_k    <= n_k;
        r_pv   <= n_pv;
        r_nv   <= n_nv;
        r_prev <= n_prev;
        r_next <= n_next;
        r_res  <= n_res;
    end

endmodule

[rtl/first_fit_extent_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top
// First-fit allocator over an address-sorted free extent table with merging.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: mode; tdata: request_size, block_address
// m_axis    out  tdata: result_address, status
// cfg       in   data: heap_size; a beat reloads the table, taken only when idle
//
// A request reads each table entry scanned (one RAM read each), moves
// entries when an extent is removed or inserted, and then decodes and
// delivers the result.
// Reset and every cfg beat write the single heap extent.
// A stalled m_axis holds one result; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size[15:0], block_address[31:16]
    input  logic [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // result_address[15:0], status[17:16], zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ffea_pkg::CFG_W-1:0] i_cfg_data
);
    import ffea_pkg::*;

    logic [LEN_W-1:0] r_heap;
    logic [LEN_W-1:0] n_heap;
    logic             cfg_beat;
    logic             ctrl_idle;
    logic             r_ovalid;
    t_res             r_out;
    t_req             req;
    t_res             res;
    logic             res_valid;
    logic             res_ready;
    t_ram_req         ram_req;
    t_ext             rdata;

    assign cfg_beat    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = ctrl_idle;

    always_comb begin
        // saturate, then drop to a granule multiple
        n_heap = (i_cfg_data > CFG_W'(HEAP_LIMIT)) ? LEN_W'(HEAP_LIMIT) : LEN_W'(i_cfg_data);
        n_heap = (n_heap >> GRN_W) << GRN_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= LEN_W'(4096);
        end else if (cfg_beat) begin
            r_heap <= n_heap;
        end
    end

    assign req.mode = s_axis_tuser[0];
    assign req.size = s_axis_tdata[15:0];
    assign req.addr = s_axis_tdata[31:16];

    ffea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (cfg_beat),
        .i_heap      (r_heap),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_rdata     (rdata),
        .o_idle      (ctrl_idle)
    );

    ffea_ram #(
        .WIDTH (EXT_W),
        .DEPTH (MAX_EXTENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    assign res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_out.status, r_out.addr};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_cfg_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_beat |=> !s_axis_tready)
        else $error("request taken during table reload");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.addr != '0 |-> r_out.status == ST_OK)
        else $error("nonzero address on a failed request");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_out))
        else $error("pending result lost");
`endif

endmodule
